/* rtl/pfa_pkg.sv */
// Shared constants and codes for the page frame allocator.
// No dependencies; imported by the core and by its port checker.
package pfa_pkg;

	// Default sizing of the frame pool and of the owner tag.
	localparam int FRAMES_DEF     = 64;
	localparam int OWNER_BITS_DEF = 16;

	// Field widths of the request and result transactions.
	localparam int OWNER_ID_W    = 16;
	localparam int PAGE_COUNT_W  = 7;
	localparam int FIRST_FRAME_W = 6;
	localparam int MOVED_W       = 7;
	localparam int FREE_FRAMES_W = 7;
	localparam int FREE_BYTES_W  = 23;
	localparam int TOTAL_W       = 32;
	localparam int OWNERS_W      = 16;
	localparam int FRAME_SIZE_W  = 17;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 128;

	// Bit positions of the result fields inside m_tdata.
	localparam int O_STATUS = 0;
	localparam int O_FIRST  = 1;
	localparam int O_MOVED  = 7;
	localparam int O_FREE   = 14;
	localparam int O_BYTES  = 21;
	localparam int O_PIN    = 44;
	localparam int O_POUT   = 76;
	localparam int O_OWNERS = 108;

	localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 17'd4096;
	localparam logic [FREE_BYTES_W-1:0] FREE_BYTES_MAX = 23'h7FFFFF;
	localparam logic [OWNERS_W-1:0]     OWNERS_MAX     = 16'hFFFF;

	// Request kinds carried on s_tuser.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes.
	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

endpackage

/* rtl/page_frame_allocator_core.sv */
// Page frame allocator core: free frame stack and owner table in synchronous RAMs.
// Depends on pfa_pkg; checked by pfa_checker through a bind.
//
// Usage. Requests arrive on the slave stream (s_tvalid/s_tready/s_tdata/s_tuser);
// s_tuser selects allocate (0) or free-all-of-owner (1), s_tdata carries the owner
// and the page count. Every request produces exactly one result transaction on the
// master stream (m_tvalid/m_tready/m_tdata). The user must write the frame size
// register through cfg_we/cfg_wdata while no request is in flight (not enforced).
//
// Timing. After reset the block sweeps both RAMs (the stack is loaded with frame
// numbers in order, the owner table is cleared); s_tready is low during that
// sweep. A request is worked on alone. An allocation pops one frame per cycle
// through the stack RAM read port; a failed allocation pops nothing and goes
// straight to the multiply. A free request walks the owner table one entry per
// cycle through its read port. The free byte count comes from one registered
// multiply at the end.
//
// Backpressure. The result sits in an output register. While it waits for
// m_tready the block still accepts and works on the next request; only the final
// load of a second result waits for the register to drain.
module page_frame_allocator_core
	import pfa_pkg::*;
#(
	parameter int FRAMES     = FRAMES_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Request stream.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata, low bit up: owner_id[15:0], page_count[22:16], zero pad [23].
	input  logic [S_TDATA_W-1:0]    s_tdata,
	// s_tuser: mode (0 allocate, 1 free).
	input  logic                    s_tuser,
	// Result stream.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata, low bit up: status[0], first_frame[6:1], frames_moved[13:7],
	// free_frames[20:14], free_bytes[43:21], pages_in_total[75:44],
	// pages_out_total[107:76], resident_owners[123:108], zero pad [127:124].
	output logic [M_TDATA_W-1:0]    m_tdata,
	// Frame size register write port.
	input  logic                    cfg_we,
	input  logic [FRAME_SIZE_W-1:0] cfg_wdata
);

	localparam int FW   = $clog2(FRAMES);
	localparam int TOPW = $clog2(FRAMES + 1);
	localparam int MW   = (TOPW > PAGE_COUNT_W) ? TOPW : PAGE_COUNT_W;
	localparam int PW   = TOPW + FRAME_SIZE_W;

	typedef struct packed {
		logic                  valid;
		logic [OWNER_BITS-1:0] owner;
	} owner_entry_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_POP   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// Both tables live in RAMs with one write and one registered read port.
	logic [FW-1:0]  stack_mem [FRAMES];
	owner_entry_t   owner_mem [FRAMES];

	state_t                  state_q;
	logic [TOPW-1:0]         top_q;
	logic [TOPW-1:0]         clr_q;
	logic [TOPW-1:0]         scan_q;
	logic [PAGE_COUNT_W-1:0] rem_q;
	logic [MW-1:0]           moved_q;
	logic [TOTAL_W-1:0]      page_in_q;
	logic [TOTAL_W-1:0]      page_out_q;
	logic [OWNERS_W-1:0]     owners_q;
	logic [FRAME_SIZE_W-1:0] frame_size_q;
	logic                    first_pend_q;
	logic                    pop_s1;
	logic                    scan_s1;
	logic                    m_valid_q;

	logic                    mode_q;
	logic                    status_q;
	logic [OWNER_BITS-1:0]   key_q;
	logic [FW-1:0]           first_q;
	logic [FW-1:0]           scan_addr_s1;
	logic [FW-1:0]           stk_rd_s1;
	owner_entry_t            own_rd_s1;
	logic [PW-1:0]           prod_q;
	logic [M_TDATA_W-1:0]    m_data_q;
	logic [M_TDATA_W-1:0]    result_word;

	// Request fields.
	logic [OWNER_ID_W-1:0]   in_owner;
	logic [PAGE_COUNT_W-1:0] in_count;
	logic                    in_accept;
	logic                    alloc_short;

	// RAM port controls.
	logic                    stk_we;
	logic [FW-1:0]           stk_waddr;
	logic [FW-1:0]           stk_wdata;
	logic [FW-1:0]           stk_raddr;
	logic                    own_we;
	logic [FW-1:0]           own_waddr;
	owner_entry_t            own_wdata;
	logic [FW-1:0]           own_raddr;

	logic [TOPW-1:0]         top_dec;
	logic                    hit;
	logic                    push_ok;
	logic                    out_free;
	logic [FREE_BYTES_W-1:0] bytes_sat;

	assign in_owner    = s_tdata[OWNER_ID_W-1:0];
	assign in_count    = s_tdata[OWNER_ID_W +: PAGE_COUNT_W];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_accept   = s_tvalid && s_tready;
	assign alloc_short = MW'(in_count) > MW'(top_q);

	assign top_dec  = top_q - TOPW'(1);
	assign hit      = scan_s1 && own_rd_s1.valid && (own_rd_s1.owner == key_q);
	assign push_ok  = top_q < TOPW'(FRAMES);
	assign out_free = !m_valid_q || m_tready;

	// Saturate the byte count to the width of its result field.
	assign bytes_sat = (64'(prod_q) > 64'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX
	                                                       : FREE_BYTES_W'(prod_q);

	// RAM port steering; the states never drive the same port at once.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = clr_q[FW-1:0];
		stk_wdata = clr_q[FW-1:0];
		own_we    = 1'b0;
		own_waddr = clr_q[FW-1:0];
		own_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				stk_we = 1'b1;
				own_we = 1'b1;
			end
			ST_POP: begin
				// A popped frame is tagged with its new owner in the cycle after its stack read.
				own_we    = pop_s1;
				own_waddr = stk_rd_s1;
				own_wdata = '{valid: 1'b1, owner: key_q};
			end
			ST_SCAN: begin
				// A matching entry is released and its frame goes back on the stack if there is room.
				own_we    = hit;
				own_waddr = scan_addr_s1;
				stk_we    = hit && push_ok;
				stk_waddr = top_q[FW-1:0];
				stk_wdata = scan_addr_s1;
			end
			default: begin
			end
		endcase
	end

	assign stk_raddr = top_dec[FW-1:0];
	assign own_raddr = scan_q[FW-1:0];

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_s1 <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[own_waddr] <= own_wdata;
		end
		own_rd_s1 <= owner_mem[own_raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			top_q        <= TOPW'(FRAMES);
			clr_q        <= '0;
			scan_q       <= '0;
			rem_q        <= '0;
			moved_q      <= '0;
			page_in_q    <= '0;
			page_out_q   <= '0;
			owners_q     <= '0;
			frame_size_q <= FRAME_SIZE_RST;
			first_pend_q <= 1'b0;
			pop_s1       <= 1'b0;
			scan_s1      <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_size_q <= cfg_wdata;
			end
			// A new result is loaded when the register is empty or drains this cycle.
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + TOPW'(1);
					if (clr_q == TOPW'(FRAMES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						if (s_tuser == MODE_FREE) begin
							if (owners_q != '0) begin
								owners_q <= owners_q - OWNERS_W'(1);
							end
							moved_q <= '0;
							scan_q  <= '0;
							scan_s1 <= 1'b0;
							state_q <= ST_SCAN;
						end else if (alloc_short) begin
							moved_q <= '0;
							state_q <= ST_MUL;
						end else begin
							if (owners_q != OWNERS_MAX) begin
								owners_q <= owners_q + OWNERS_W'(1);
							end
							moved_q      <= MW'(in_count);
							rem_q        <= in_count;
							first_pend_q <= 1'b1;
							pop_s1       <= 1'b0;
							state_q      <= ST_POP;
						end
					end
				end
				ST_POP: begin
					if (pop_s1) begin
						first_pend_q <= 1'b0;
					end
					if (rem_q != '0) begin
						top_q  <= top_dec;
						rem_q  <= rem_q - PAGE_COUNT_W'(1);
						pop_s1 <= 1'b1;
					end else begin
						pop_s1 <= 1'b0;
						if (!pop_s1) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						moved_q <= moved_q + MW'(1);
						if (push_ok) begin
							top_q <= top_q + TOPW'(1);
						end
					end
					if (scan_q != TOPW'(FRAMES)) begin
						scan_q  <= scan_q + TOPW'(1);
						scan_s1 <= 1'b1;
					end else begin
						scan_s1 <= 1'b0;
						if (!scan_s1) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mode_q == MODE_FREE) begin
						page_out_q <= page_out_q + TOTAL_W'(moved_q);
					end else begin
						page_in_q <= page_in_q + TOTAL_W'(moved_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result word, packed from the low bit up.
	always_comb begin
		result_word                                = '0;
		result_word[O_STATUS]                      = status_q;
		result_word[O_FIRST +: FIRST_FRAME_W]      = FIRST_FRAME_W'(first_q);
		result_word[O_MOVED +: MOVED_W]            = MOVED_W'(moved_q);
		result_word[O_FREE +: FREE_FRAMES_W]       = FREE_FRAMES_W'(top_q);
		result_word[O_BYTES +: FREE_BYTES_W]       = bytes_sat;
		result_word[O_PIN +: TOTAL_W]              = page_in_q;
		result_word[O_POUT +: TOTAL_W]             = page_out_q;
		result_word[O_OWNERS +: OWNERS_W]          = owners_q;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q   <= s_tuser;
			key_q    <= OWNER_BITS'(in_owner);
			first_q  <= '0;
			status_q <= ((s_tuser == MODE_ALLOC) && alloc_short) ? STATUS_SHORT
			                                                     : STATUS_DONE;
		end
		if ((state_q == ST_POP) && pop_s1 && first_pend_q) begin
			first_q <= stk_rd_s1;
		end
		if (state_q == ST_SCAN) begin
			scan_addr_s1 <= scan_q[FW-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(top_q) * PW'(frame_size_q);
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_data_q <= result_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* rtl/pfa_checker.sv */
// Port-level checker for the page frame allocator core, attached by bind.
// Depends on pfa_pkg for the result field positions.
module pfa_checker
	import pfa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A waiting result is held until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// Requests are worked on one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request accepted while one is in flight");

	// A refused allocation moves no frames.
	a_short_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[O_STATUS] == STATUS_SHORT)
		|-> m_tdata[O_MOVED +: MOVED_W] == '0)
		else $error("refused allocation reports moved frames");

	// A refused allocation reports no first frame.
	a_short_no_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[O_STATUS] == STATUS_SHORT)
		|-> m_tdata[O_FIRST +: FIRST_FRAME_W] == '0)
		else $error("refused allocation reports a first frame");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
